FILE: src/lrni_pkg.sv
// lrni_pkg: shared constants, datapath operation codes and status type
// for the lidar range noise injector. No dependencies.

package lrni_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned APB_AW          = 4;
  localparam int unsigned APB_DW          = 32;
  localparam int unsigned ENTRY_W         = 48;

  localparam logic [APB_AW-3:0] REG_MODE    = 2'd0;
  localparam logic [APB_AW-3:0] REG_AMOUNT  = 2'd1;
  localparam logic [APB_AW-3:0] REG_ENTRIES = 2'd2;

  localparam logic [1:0] MODE_FIXED = 2'd0;
  localparam logic [1:0] MODE_PROP  = 2'd1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQX,
    OP_SQY,
    OP_SQZ,
    OP_SQSUM,
    OP_SQRT,
    OP_NMUL_AMT,
    OP_MUL_R,
    OP_D_SH15,
    OP_D_SH16,
    OP_WALK_INIT,
    OP_WALK_RD,
    OP_WALK_NEXT,
    OP_E_SET,
    OP_E_PREV,
    OP_E_ZERO,
    OP_IMUL,
    OP_IDIV_LD,
    OP_DIV,
    OP_E_INTERP,
    OP_NMUL_E,
    OP_NEWR,
    OP_PMUL_LO,
    OP_PMUL_HI,
    OP_PDIV_LD,
    OP_COORD,
    OP_ORIGIN_D,
    OP_ORIGIN_Z,
    OP_OUT
  } op_e;

  typedef struct packed {
    logic cnt_last;
    logic r_zero;
    logic walk_end;
    logic k_zero;
    logic dist_eq;
    logic dist_lt;
    logic coord_last;
    logic slot_free;
  } sts_t;

endpackage

FILE: src/lrni_if.sv
// lrni_if: valid/ready channel interfaces for point items and results.
// No dependencies.

interface lrni_item_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [5:0]         entry_index;
  logic [15:0]        entry_distance;
  logic [31:0]        entry_error;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [15:0] noise_sample;

  modport source (
    output valid, command, entry_index, entry_distance, entry_error,
    output point_x, point_y, point_z, noise_sample,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, entry_distance, entry_error,
    input  point_x, point_y, point_z, noise_sample,
    output ready
  );
endinterface

interface lrni_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] noisy_x;
  logic signed [31:0] noisy_y;
  logic signed [31:0] noisy_z;

  modport source (output valid, noisy_x, noisy_y, noisy_z, input ready);
  modport sink (input valid, noisy_x, noisy_y, noisy_z, output ready);
endinterface

FILE: src/lidar_range_noise_injector.sv
// lidar_range_noise_injector: top level with APB registers, table RAM,
// controller and datapath. Depends on lrni_pkg, lrni_if, lrni_ram, lrni_ctrl, lrni_dp.

// A table write item is written to the table RAM as it is accepted and gives
// no result. A point item goes in order: the squares are formed and summed,
// 32 square root steps run, the noise term is a product and a shift in mode 0
// (with a further multiply by the range in mode 1), and the new range is
// formed. Then per coordinate: two partial products and 32 restoring divide
// steps on one shared 32x32 multiplier and one divider. Last the output
// register is loaded. Modes 2 and 3 add an error product and a table walk:
// each entry is a registered RAM read and a compare, the walk stops past the
// last valid entry, and the error may be interpolated. A point at the origin
// skips the coordinate scaling. The result sits in an output register, so the
// next item is taken while it waits. A point that finishes while the previous
// result still waits holds there. The table RAM needs no clearing pass.
module lidar_range_noise_injector #(
  parameter int unsigned TABLE_DEPTH = lrni_pkg::DEF_TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrni_pkg::APB_AW-1:0]   paddr,
  input  logic [lrni_pkg::APB_DW-1:0]   pwdata,
  output logic [lrni_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  lrni_item_if.sink                     item_i,
  lrni_res_if.source                    result_o
);
  import lrni_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [1:0]  mode_q;
  logic [31:0] amount_q;
  logic [6:0]  entries_q;

  logic [APB_AW-3:0] reg_idx;
  logic              cfg_we;

  op_e                op;
  sts_t               sts;
  logic               item_ready;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      amount_q  <= '0;
      entries_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_MODE:    mode_q    <= pwdata[1:0];
        REG_AMOUNT:  amount_q  <= pwdata;
        REG_ENTRIES: entries_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:    prdata = {30'd0, mode_q};
      REG_AMOUNT:  prdata = amount_q;
      REG_ENTRIES: prdata = {25'd0, entries_q};
      default:     prdata = '0;
    endcase
  end

  assign item_i.ready = item_ready;
  assign ram_we = item_i.valid && item_ready && !item_i.command
               && (32'(item_i.entry_index) < TABLE_DEPTH);

  lrni_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(item_i.entry_index)),
    .wdata_i ({item_i.entry_distance, item_i.entry_error}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lrni_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_i.valid),
    .item_command_i (item_i.command),
    .error_mode_i   (mode_q),
    .sts_i          (sts),
    .item_ready_o   (item_ready),
    .op_o           (op)
  );

  lrni_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .point_x_i       (item_i.point_x),
    .point_y_i       (item_i.point_y),
    .point_z_i       (item_i.point_z),
    .noise_sample_i  (item_i.noise_sample),
    .error_amount_i  (amount_q),
    .table_entries_i (entries_q),
    .ram_rdata_i     (ram_rdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .out_ready_i     (result_o.ready),
    .out_valid_o     (result_o.valid),
    .noisy_x_o       (result_o.noisy_x),
    .noisy_y_o       (result_o.noisy_y),
    .noisy_z_o       (result_o.noisy_z),
    .sts_o           (sts)
  );

  a_ram_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table write and walk read in the same cycle");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(op == OP_OUT))
    else $error("result valid rose without an output load");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready && item_i.command) |=> !item_i.ready)
    else $error("point transaction accepted while busy");

endmodule

FILE: src/lrni_ram.sv
// lrni_ram: generic single write port, single read port RAM with registered read.
// No dependencies.

module lrni_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/lrni_dp.sv
// lrni_dp: datapath with shared multiplier, square root and divider steps,
// table walk registers and output register. Depends on lrni_pkg.

module lrni_dp #(
  parameter int unsigned TABLE_DEPTH = lrni_pkg::DEF_TABLE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lrni_pkg::op_e                  op_i,
  input  logic signed [31:0]             point_x_i,
  input  logic signed [31:0]             point_y_i,
  input  logic signed [31:0]             point_z_i,
  input  logic signed [15:0]             noise_sample_i,
  input  logic [31:0]                    error_amount_i,
  input  logic [6:0]                     table_entries_i,
  input  logic [lrni_pkg::ENTRY_W-1:0]   ram_rdata_i,
  output logic                           ram_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [31:0]             noisy_x_o,
  output logic signed [31:0]             noisy_y_o,
  output logic signed [31:0]             noisy_z_o,
  output lrni_pkg::sts_t                 sts_o
);
  import lrni_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned KW = $clog2(TABLE_DEPTH + 1);

  logic [31:0] pm_q [3];
  logic        pneg_q [3];
  logic [15:0] nmag_q;
  logic        nneg_q;
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [31:0] root_q;
  logic [34:0] srem_q;
  logic [4:0]  cnt_q;
  logic [47:0] d_q;
  logic [48:0] rmag_q;
  logic        rneg_q;
  logic [KW-1:0] k_q;
  logic [15:0] prev_dist_q;
  logic [31:0] prev_err_q;
  logic [31:0] e_q;
  logic [31:0] drem_q;
  logic [31:0] dl_q;
  logic [31:0] dv_q;
  logic [31:0] q_q;
  logic        ovf_q;
  logic [63:0] plo_q;
  logic [1:0]  idx_q;
  logic [31:0] res_q [3];
  logic        out_valid_q;
  logic [31:0] out_x_q, out_y_q, out_z_q;

  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [31:0] ux, uy, uz;
  logic [15:0] un;
  logic [31:0] pm_sel;
  logic [34:0] srem_n, trial;
  logic        sq_ge;
  logic [32:0] dt;
  logic        dge;
  logic [48:0] ph;
  logic [48:0] r49, d49;
  logic [15:0] rd_dist;
  logic [31:0] rd_err;
  logic [31:0] num, den, diff;
  logic        up;
  logic [KW-1:0] m_w;
  logic        cbig, cneg, obig;
  logic [31:0] coord_sat, orig_sat;
  logic        slot_free;

  assign ux = point_x_i;
  assign uy = point_y_i;
  assign uz = point_z_i;
  assign un = noise_sample_i;

  assign pm_sel  = pm_q[idx_q];
  assign rd_dist = ram_rdata_i[47:32];
  assign rd_err  = ram_rdata_i[31:0];

  assign srem_n = {srem_q[32:0], acc_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign sq_ge  = srem_n >= trial;

  assign dt  = {drem_q, dl_q[31]};
  assign dge = dt >= {1'b0, dv_q};

  assign ph  = {1'b0, prod_q[47:0]} + {17'd0, plo_q[63:32]};
  assign r49 = {17'd0, root_q};
  assign d49 = {1'b0, d_q};

  assign num  = root_q - {prev_dist_q, 16'd0};
  assign den  = {rd_dist, 16'd0} - {prev_dist_q, 16'd0};
  assign up   = rd_err >= prev_err_q;
  assign diff = up ? (rd_err - prev_err_q) : (prev_err_q - rd_err);

  assign m_w = (32'(table_entries_i) > TABLE_DEPTH) ? KW'(TABLE_DEPTH)
                                                     : KW'(table_entries_i);

  assign cneg      = pneg_q[idx_q] ^ rneg_q;
  assign cbig      = ovf_q | q_q[31];
  assign coord_sat = cneg ? (cbig ? 32'h8000_0000 : (~q_q + 32'd1))
                          : (cbig ? 32'h7fff_ffff : q_q);
  assign obig      = |d_q[47:31];
  assign orig_sat  = nneg_q ? (obig ? 32'h8000_0000 : (~d_q[31:0] + 32'd1))
                            : (obig ? 32'h7fff_ffff : d_q[31:0]);

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (op_i)
      OP_SQX: begin
        mul_a = pm_q[0];
        mul_b = pm_q[0];
      end
      OP_SQY: begin
        mul_a = pm_q[1];
        mul_b = pm_q[1];
      end
      OP_SQZ: begin
        mul_a = pm_q[2];
        mul_b = pm_q[2];
      end
      OP_NMUL_AMT: begin
        mul_a = {16'd0, nmag_q};
        mul_b = error_amount_i;
      end
      OP_MUL_R: begin
        mul_a = prod_q[46:15];
        mul_b = root_q;
      end
      OP_NMUL_E: begin
        mul_a = {16'd0, nmag_q};
        mul_b = e_q;
      end
      OP_IMUL: begin
        mul_a = diff;
        mul_b = num;
      end
      OP_PMUL_LO: begin
        mul_a = pm_sel;
        mul_b = rmag_q[31:0];
      end
      OP_PMUL_HI: begin
        mul_a = pm_sel;
        mul_b = {15'd0, rmag_q[48:32]};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // control counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (op_i)
        OP_SQSUM, OP_IDIV_LD, OP_PDIV_LD: cnt_q <= '0;
        OP_SQRT, OP_DIV:                  cnt_q <= cnt_q + 5'd1;
        OP_NEWR:                          idx_q <= '0;
        OP_COORD:                         idx_q <= idx_q + 2'd1;
        OP_WALK_INIT:                     k_q   <= '0;
        OP_WALK_NEXT:                     k_q   <= k_q + KW'(1);
        default: ;
      endcase
      if (op_i == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        pneg_q[0] <= ux[31];
        pneg_q[1] <= uy[31];
        pneg_q[2] <= uz[31];
        pm_q[0]   <= ux[31] ? (~ux + 32'd1) : ux;
        pm_q[1]   <= uy[31] ? (~uy + 32'd1) : uy;
        pm_q[2]   <= uz[31] ? (~uz + 32'd1) : uz;
        nneg_q    <= un[15];
        nmag_q    <= un[15] ? (~un + 16'd1) : un;
      end
      OP_SQY: acc_q <= prod_q;
      OP_SQZ: acc_q <= acc_q + prod_q;
      OP_SQSUM: begin
        acc_q  <= acc_q + prod_q;
        root_q <= '0;
        srem_q <= '0;
      end
      OP_SQRT: begin
        acc_q <= {acc_q[61:0], 2'b00};
        if (sq_ge) begin
          srem_q <= srem_n - trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          srem_q <= srem_n;
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      OP_D_SH15: d_q <= prod_q[62:15];
      OP_D_SH16: d_q <= prod_q[63:16];
      OP_WALK_NEXT: begin
        prev_dist_q <= rd_dist;
        prev_err_q  <= rd_err;
      end
      OP_E_SET:  e_q <= rd_err;
      OP_E_PREV: e_q <= prev_err_q;
      OP_E_ZERO: e_q <= '0;
      OP_IDIV_LD: begin
        ovf_q  <= 1'b0;
        drem_q <= prod_q[63:32];
        dl_q   <= prod_q[31:0];
        dv_q   <= den;
        q_q    <= '0;
      end
      OP_PDIV_LD: begin
        ovf_q  <= ph >= r49;
        drem_q <= ph[31:0];
        dl_q   <= plo_q[31:0];
        dv_q   <= root_q;
        q_q    <= '0;
      end
      OP_DIV: begin
        drem_q <= dge ? 32'(dt - {1'b0, dv_q}) : dt[31:0];
        dl_q   <= {dl_q[30:0], 1'b0};
        q_q    <= {q_q[30:0], dge};
      end
      OP_E_INTERP: e_q <= up ? (prev_err_q + q_q) : (prev_err_q - q_q);
      OP_NEWR: begin
        if (!nneg_q) begin
          rmag_q <= r49 + d49;
          rneg_q <= 1'b0;
        end else if (d49 > r49) begin
          rmag_q <= d49 - r49;
          rneg_q <= 1'b1;
        end else begin
          rmag_q <= r49 - d49;
          rneg_q <= 1'b0;
        end
      end
      OP_PMUL_HI: plo_q <= prod_q;
      OP_COORD:   res_q[idx_q] <= coord_sat;
      OP_ORIGIN_D: begin
        res_q[0] <= orig_sat;
        res_q[1] <= '0;
        res_q[2] <= '0;
      end
      OP_ORIGIN_Z: begin
        res_q[0] <= '0;
        res_q[1] <= '0;
        res_q[2] <= '0;
      end
      OP_OUT: begin
        out_x_q <= res_q[0];
        out_y_q <= res_q[1];
        out_z_q <= res_q[2];
      end
      default: ;
    endcase
  end

  assign ram_re_o    = op_i == OP_WALK_RD;
  assign ram_raddr_o = k_q[AW-1:0];

  assign out_valid_o = out_valid_q;
  assign noisy_x_o   = out_x_q;
  assign noisy_y_o   = out_y_q;
  assign noisy_z_o   = out_z_q;

  assign sts_o.cnt_last   = cnt_q == 5'd31;
  assign sts_o.r_zero     = root_q == '0;
  assign sts_o.walk_end   = k_q >= m_w;
  assign sts_o.k_zero     = k_q == '0;
  assign sts_o.dist_eq    = rd_dist == root_q[31:16];
  assign sts_o.dist_lt    = rd_dist < root_q[31:16];
  assign sts_o.coord_last = idx_q == 2'd2;
  assign sts_o.slot_free  = slot_free;

endmodule

FILE: src/lrni_ctrl.sv
// lrni_ctrl: sequencing state machine that issues datapath operations.
// Depends on lrni_pkg.

module lrni_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  logic           item_command_i,
  input  logic [1:0]     error_mode_i,
  input  lrni_pkg::sts_t sts_i,
  output logic           item_ready_o,
  output lrni_pkg::op_e  op_o
);
  import lrni_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SQX    = 5'd1;
  localparam logic [4:0] S_SQY    = 5'd2;
  localparam logic [4:0] S_SQZ    = 5'd3;
  localparam logic [4:0] S_SQSUM  = 5'd4;
  localparam logic [4:0] S_SQRT   = 5'd5;
  localparam logic [4:0] S_NOISE  = 5'd6;
  localparam logic [4:0] S_D15    = 5'd7;
  localparam logic [4:0] S_M1     = 5'd8;
  localparam logic [4:0] S_M1D    = 5'd9;
  localparam logic [4:0] S_WRD    = 5'd10;
  localparam logic [4:0] S_WCHK   = 5'd11;
  localparam logic [4:0] S_ILD    = 5'd12;
  localparam logic [4:0] S_IDIV   = 5'd13;
  localparam logic [4:0] S_IFIN   = 5'd14;
  localparam logic [4:0] S_NMULE  = 5'd15;
  localparam logic [4:0] S_NEWR   = 5'd16;
  localparam logic [4:0] S_PLO    = 5'd17;
  localparam logic [4:0] S_PHI    = 5'd18;
  localparam logic [4:0] S_PLD    = 5'd19;
  localparam logic [4:0] S_PDIV   = 5'd20;
  localparam logic [4:0] S_PSAT   = 5'd21;
  localparam logic [4:0] S_ORIGIN = 5'd22;
  localparam logic [4:0] S_OUT    = 5'd23;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    op_o         = OP_NONE;
    item_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i && item_command_i) begin
          op_o    = OP_LOAD;
          state_d = S_SQX;
        end
      end
      S_SQX: begin
        op_o    = OP_SQX;
        state_d = S_SQY;
      end
      S_SQY: begin
        op_o    = OP_SQY;
        state_d = S_SQZ;
      end
      S_SQZ: begin
        op_o    = OP_SQZ;
        state_d = S_SQSUM;
      end
      S_SQSUM: begin
        op_o    = OP_SQSUM;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        op_o = OP_SQRT;
        if (sts_i.cnt_last) begin
          state_d = S_NOISE;
        end
      end
      S_NOISE: begin
        if (error_mode_i == MODE_FIXED) begin
          op_o    = OP_NMUL_AMT;
          state_d = S_D15;
        end else if (error_mode_i == MODE_PROP) begin
          op_o    = OP_NMUL_AMT;
          state_d = S_M1;
        end else if (sts_i.r_zero) begin
          state_d = S_ORIGIN;
        end else begin
          op_o    = OP_WALK_INIT;
          state_d = S_WRD;
        end
      end
      S_D15: begin
        op_o    = OP_D_SH15;
        state_d = sts_i.r_zero ? S_ORIGIN : S_NEWR;
      end
      S_M1: begin
        op_o    = OP_MUL_R;
        state_d = S_M1D;
      end
      S_M1D: begin
        op_o    = OP_D_SH16;
        state_d = sts_i.r_zero ? S_ORIGIN : S_NEWR;
      end
      S_WRD: begin
        if (sts_i.walk_end) begin
          op_o    = sts_i.k_zero ? OP_E_ZERO : OP_E_PREV;
          state_d = S_NMULE;
        end else begin
          op_o    = OP_WALK_RD;
          state_d = S_WCHK;
        end
      end
      S_WCHK: begin
        if (sts_i.dist_eq) begin
          op_o    = OP_E_SET;
          state_d = S_NMULE;
        end else if (sts_i.dist_lt) begin
          op_o    = OP_WALK_NEXT;
          state_d = S_WRD;
        end else if (sts_i.k_zero) begin
          op_o    = OP_E_ZERO;
          state_d = S_NMULE;
        end else begin
          op_o    = OP_IMUL;
          state_d = S_ILD;
        end
      end
      S_ILD: begin
        op_o    = OP_IDIV_LD;
        state_d = S_IDIV;
      end
      S_IDIV: begin
        op_o = OP_DIV;
        if (sts_i.cnt_last) begin
          state_d = S_IFIN;
        end
      end
      S_IFIN: begin
        op_o    = OP_E_INTERP;
        state_d = S_NMULE;
      end
      S_NMULE: begin
        op_o    = OP_NMUL_E;
        state_d = S_D15;
      end
      S_NEWR: begin
        op_o    = OP_NEWR;
        state_d = S_PLO;
      end
      S_PLO: begin
        op_o    = OP_PMUL_LO;
        state_d = S_PHI;
      end
      S_PHI: begin
        op_o    = OP_PMUL_HI;
        state_d = S_PLD;
      end
      S_PLD: begin
        op_o    = OP_PDIV_LD;
        state_d = S_PDIV;
      end
      S_PDIV: begin
        op_o = OP_DIV;
        if (sts_i.cnt_last) begin
          state_d = S_PSAT;
        end
      end
      S_PSAT: begin
        op_o    = OP_COORD;
        state_d = sts_i.coord_last ? S_OUT : S_PLO;
      end
      S_ORIGIN: begin
        op_o    = (error_mode_i == MODE_FIXED) ? OP_ORIGIN_D : OP_ORIGIN_Z;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.slot_free) begin
          op_o    = OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sim/tb_lidar_range_noise_injector.sv
// tb_lidar_range_noise_injector: self-checking bench for the range noise injector.
// Drives table and point transactions with random idling and checks every result
// against a fixed-point predictor. Depends on lrni_pkg, lrni_if and the RTL.
`timescale 1ns / 100ps

module tb_lidar_range_noise_injector;
  import lrni_pkg::*;

  localparam bit CMD_TABLE = 1'b0;
  localparam bit CMD_POINT = 1'b1;
  localparam logic [1:0] MODE_TABLE = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int DEPTH = 64;
  localparam int WDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    bit               cmd;
    bit [5:0]         idx;
    bit [15:0]        edist;
    bit [31:0]        err;
    bit signed [31:0] x;
    bit signed [31:0] y;
    bit signed [31:0] z;
    bit signed [15:0] noise;
  } xact_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  lrni_item_if item_bus ();
  lrni_res_if  res_bus ();

  lidar_range_noise_injector dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .item_i   (item_bus),
    .result_o (res_bus)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // predictor state
  logic [1:0]  cur_mode;
  logic [31:0] cur_amount;
  logic [6:0]  cur_entries;
  logic [15:0] dist_mem [DEPTH];
  logic [31:0] err_mem [DEPTH];

  xact_t  backlog_q [$];
  point_t noisy_pts_q [$];
  xact_t  on_bus;
  int     errors;
  int     src_idle_pct, snk_idle_pct;
  bit     hold_on;
  int     hold_cnt;
  int     wdog;

  function automatic void queue_item(xact_t it);
    backlog_q.insert(backlog_q.size(), it);
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] rem, res, b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] sat32(bit neg, logic [63:0] mag);
    if (neg) begin
      if (mag >= 64'h8000_0000) return 32'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    return (mag > 64'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
  endfunction

  function automatic logic [31:0] lookup_error(logic [63:0] r);
    int          m, k;
    logic [63:0] t, lo, den, num, diff, part;
    logic [31:0] e0, e1;
    m = (cur_entries > DEPTH) ? DEPTH : int'(cur_entries);
    t = r >> 16;
    k = 0;
    while (k < m && dist_mem[k] <= t) begin
      if (dist_mem[k] == t) return err_mem[k];
      k++;
    end
    if (k == 0) return 32'd0;
    if (k == m) return err_mem[m-1];
    lo = {32'd0, dist_mem[k-1], 16'd0};
    den = {32'd0, dist_mem[k], 16'd0} - lo;
    num = r - lo;
    e0 = err_mem[k-1];
    e1 = err_mem[k];
    diff = (e1 >= e0) ? {32'd0, e1 - e0} : {32'd0, e0 - e1};
    part = diff * num / den;
    return (e1 >= e0) ? e0 + part[31:0] : e0 - part[31:0];
  endfunction

  function automatic logic [31:0] scale_coord(bit pneg, logic [63:0] pmag, bit rneg,
                                              logic [63:0] rmag, logic [63:0] r);
    logic [63:0] q, rm, mag;
    q = rmag / r;
    rm = rmag % r;
    if (pmag == 0) return 32'd0;
    if (q >= (64'd1 << 33)) return sat32(pneg != rneg, 64'd1 << 33);
    mag = pmag * q + (pmag * rm) / r;
    return sat32(pneg != rneg, mag);
  endfunction

  function automatic logic [63:0] abs32(bit signed [31:0] v);
    return v[31] ? 64'h1_0000_0000 - {32'd0, v} : {32'd0, v};
  endfunction

  function automatic void compute_noisy_point(xact_t it);
    logic [63:0] mx, my, mz, nmag, r, d, rmag;
    logic signed [64:0] nr;
    bit nneg, rneg;
    point_t p;
    if (it.cmd == CMD_TABLE) begin
      dist_mem[it.idx] = it.edist;
      err_mem[it.idx] = it.err;
      return;
    end
    mx = abs32(it.x);
    my = abs32(it.y);
    mz = abs32(it.z);
    nneg = it.noise[15];
    nmag = nneg ? 64'h1_0000 - {48'd0, it.noise} : {48'd0, it.noise};
    r = isqrt64(mx * mx + my * my + mz * mz);
    if (cur_mode == MODE_FIXED) d = (nmag * cur_amount) >> 15;
    else if (cur_mode == MODE_PROP) d = (((nmag * cur_amount) >> 15) * r) >> 16;
    else d = (r == 0) ? 64'd0 : (nmag * lookup_error(r)) >> 15;
    if (r == 0) begin
      p.x = (cur_mode == MODE_FIXED) ? sat32(nneg, d) : 32'd0;
      p.y = 32'd0;
      p.z = 32'd0;
    end else begin
      if (nneg) nr = $signed({1'b0, r}) - $signed({1'b0, d});
      else nr = $signed({1'b0, r}) + $signed({1'b0, d});
      rneg = nr < 0;
      rmag = rneg ? 64'(-nr) : 64'(nr);
      p.x = scale_coord(it.x[31], mx, rneg, rmag, r);
      p.y = scale_coord(it.y[31], my, rneg, rmag, r);
      p.z = scale_coord(it.z[31], mz, rneg, rmag, r);
    end
    noisy_pts_q.insert(noisy_pts_q.size(), p);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_bus.valid && item_bus.ready) compute_noisy_point(on_bus);
      if (!item_bus.valid || item_bus.ready) begin
        if (backlog_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          on_bus = backlog_q.pop_front();
          item_bus.valid          <= 1'b1;
          item_bus.command        <= on_bus.cmd;
          item_bus.entry_index    <= on_bus.idx;
          item_bus.entry_distance <= on_bus.edist;
          item_bus.entry_error    <= on_bus.err;
          item_bus.point_x        <= on_bus.x;
          item_bus.point_y        <= on_bus.y;
          item_bus.point_z        <= on_bus.z;
          item_bus.noise_sample   <= on_bus.noise;
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        if (noisy_pts_q.size() == 0) begin
          $display("%0t: unexpected transaction x=%h y=%h z=%h", $time,
                   res_bus.noisy_x, res_bus.noisy_y, res_bus.noisy_z);
          errors++;
        end else begin
          want = noisy_pts_q.pop_front();
          if (res_bus.noisy_x !== want.x) begin
            $display("%0t: noisy_x expected %h actual %h", $time, want.x, res_bus.noisy_x);
            errors++;
          end
          if (res_bus.noisy_y !== want.y) begin
            $display("%0t: noisy_y expected %h actual %h", $time, want.y, res_bus.noisy_y);
            errors++;
          end
          if (res_bus.noisy_z !== want.z) begin
            $display("%0t: noisy_z expected %h actual %h", $time, want.z, res_bus.noisy_z);
            errors++;
          end
        end
      end
      res_bus.ready <= !(hold_on && hold_cnt < HOLD_CYCLES) &&
                       ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_on && hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
  end

  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic reg_write(logic [APB_AW-3:0] regno, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regno, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (regno == REG_MODE) cur_mode = val[1:0];
    else if (regno == REG_AMOUNT) cur_amount = val;
    else if (regno == REG_ENTRIES) cur_entries = val[6:0];
  endtask

  task automatic drain();
    while (backlog_q.size() > 0 || item_bus.valid || noisy_pts_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic xact_t table_xact(int idx, logic [15:0] edist, logic [31:0] err);
    xact_t it;
    it = '{default: '0};
    it.cmd = CMD_TABLE;
    it.idx = 6'(idx);
    it.edist = edist;
    it.err = err;
    return it;
  endfunction

  function automatic xact_t point_xact(int x, int y, int z, int n);
    xact_t it;
    it = '{default: '0};
    it.cmd = CMD_POINT;
    it.x = x;
    it.y = y;
    it.z = z;
    it.noise = 16'(n);
    it.idx = 6'($urandom);
    it.edist = 16'($urandom);
    it.err = $urandom;
    return it;
  endfunction

  // ascending distances with random errors, optionally starting above zero
  task automatic load_table();
    int          d;
    logic [31:0] e;
    d = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
    for (int i = 0; i < DEPTH; i++) begin
      e = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom;
      queue_item(table_xact(i, 16'(d), e));
      d = d + $urandom_range(1, 700);
    end
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return int'($urandom) >>> $urandom_range(0, 31);
      2: return $urandom_range(0, 3) - 1;
      default: return int'($urandom) >>> $urandom_range(8, 20);
    endcase
  endfunction

  function automatic xact_t rand_xact();
    int k, dv;
    case ($urandom_range(0, 19))
      0, 1: return table_xact($urandom_range(0, DEPTH - 1), 16'($urandom), $urandom);
      2, 3, 4: begin
        k = $urandom_range(0, DEPTH - 1);
        dv = dist_mem[k] + $urandom_range(0, 1);
        if (dv > 32767) dv = $urandom_range(0, 32767);
        return point_xact($urandom_range(0, 1) ? dv << 16 : -(dv << 16), 0, 0, $urandom);
      end
      default: return point_xact(rand_coord(), rand_coord(), rand_coord(), $urandom);
    endcase
  endfunction

  logic [1:0]  ph_mode [12] = '{MODE_FIXED, MODE_PROP, MODE_TABLE, MODE_FIXED, MODE_PROP,
                                 MODE_TABLE, MODE_SPARE, MODE_FIXED, MODE_TABLE, MODE_PROP,
                                 MODE_TABLE, MODE_FIXED};
  logic [31:0] ph_amount [12] = '{32'h0001_0000, 32'h0001_0000, 32'h0, 32'hffff_ffff,
                                  32'hffff_ffff, 32'h0002_8000, 32'h1234, 32'h0, 32'h0,
                                  32'h0000_4000, 32'h5, 32'h0};
  logic [6:0]  ph_entries [12] = '{7'd0, 7'd0, 7'd64, 7'd0, 7'd1, 7'd1, 7'd127, 7'd0,
                                   7'd17, 7'd0, 7'd0, 7'd64};

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_bus.valid = 1'b0;
    item_bus.command = 1'b0;
    item_bus.entry_index = '0;
    item_bus.entry_distance = '0;
    item_bus.entry_error = '0;
    item_bus.point_x = '0;
    item_bus.point_y = '0;
    item_bus.point_z = '0;
    item_bus.noise_sample = '0;
    res_bus.ready = 1'b0;
    cur_mode = MODE_FIXED;
    cur_amount = '0;
    cur_entries = '0;
    errors = 0;
    hold_on = 1'b0;
    hold_cnt = 0;
    wdog = 0;
    src_idle_pct = 29;
    snk_idle_pct = 83;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    load_table();
    drain();
    for (int p = 0; p < 12; p++) begin
      src_idle_pct <= (p < 4) ? 29 : (p < 8) ? 83 : 0;
      snk_idle_pct <= (p < 4) ? 83 : (p < 8) ? 29 : 0;
      if (p == 5 || p == 8) begin
        load_table();
        drain();
      end
      reg_write(REG_MODE, 32'(ph_mode[p]));
      reg_write(REG_AMOUNT, (p == 11) ? $urandom : ph_amount[p]);
      reg_write(REG_ENTRIES, (p == 8) ? 32'($urandom_range(2, 63)) : 32'(ph_entries[p]));
      // origin, coordinate extremes, noise extremes
      queue_item(point_xact(0, 0, 0, 16'sh7fff));
      queue_item(point_xact(0, 0, 0, -32768));
      if (p < 3) begin
        queue_item(point_xact(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -32768));
        queue_item(point_xact(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32767));
        queue_item(point_xact(32'h7fff_ffff, -1, 1, 0));
        queue_item(point_xact(1, 0, 0, -32768));
        queue_item(point_xact(int'(dist_mem[0]) << 16, 0, 0, 32767));
        queue_item(point_xact(int'(dist_mem[DEPTH-1]) << 16, 5, 0, -1));
        queue_item(point_xact(32'h0001_0000, 0, 0, 32767));
      end
      if (p == 2) begin
        hold_on <= 1'b1;
        for (int i = 0; i < 60; i++) queue_item(rand_xact());
        while (hold_cnt < HOLD_CYCLES) @(posedge clk_i);
      end
      for (int i = 0; i < 138; i++) queue_item(rand_xact());
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
src/lrni_pkg.sv
src/lrni_if.sv
src/lrni_ram.sv
src/lrni_dp.sv
src/lrni_ctrl.sv
src/lidar_range_noise_injector.sv
sim/tb_lidar_range_noise_injector.sv
